### hw/rtl/quicksort_engine_defines.svh
// Assertion macros for the quicksort engine.
`ifndef QUICKSORT_ENGINE_DEFINES_SVH
`define QUICKSORT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define QSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/qse_pkg.sv
// Shared types for the quicksort engine.
package qse_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_POP,
    ST_POP_W,
    ST_PIV,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SWAP2,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

### hw/rtl/qse_key_ram.sv
// Key store: one write port, two registered read ports.
module qse_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/quicksort_engine.sv
// Quicksort engine top level: load, Lomuto partition sort, ordered emission.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata key_in, s_tlast last_in
//   m_*     | out | m_tvalid/m_tready  | m_tdata sorted_key, m_tlast, m_tuser overflow
//   cfg_*   | in  | cfg_valid/cfg_ready| cfg_data signed_compare
//
// Loading takes one beat per cycle while s_tready is high; the last beat starts
// the sort from the key store. A compare reads, then compares; a swap adds a
// write; a popped range is skipped or pivoted, partitioned, written twice and
// pushed. Emission reads each key, then loads it into the output register when
// it is free. Reset is synchronous; stores need no clearing. s_tready is low
// from the last beat until the final key is loaded.
`include "quicksort_engine_defines.svh"

module quicksort_engine #(
  parameter int MAX_KEYS  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_key
  output logic        m_tlast,
  output logic        m_tuser,   // [0] overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // [0] signed_compare
);

  localparam int IW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int KIN = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  qse_pkg::state_t state, state_next;

  logic                 signed_compare;
  logic [CW-1:0]        count;
  logic                 dropped;
  logic [CW-1:0]        sp;
  logic [IW-1:0]        lo, hi, i, j, k;
  logic [KEY_WIDTH-1:0] pivot, tmp;

  logic [2*IW-1:0]      stack [MAX_KEYS];
  logic [2*IW-1:0]      stk_q;
  logic                 stk_we;
  logic [IW-1:0]        stk_wa, stk_ra;
  logic [2*IW-1:0]      stk_wd;

  logic                 we;
  logic [IW-1:0]        wa, ra, rb;
  logic [KEY_WIDTH-1:0] wd, rd_a, rd_b, key_w;
  logic [IW-1:0]        lo_d, hi_d;
  logic                 less, skip, load, out_free, s_beat;
  logic [31:0]          out_key;

  function automatic logic [KEY_WIDTH-1:0] ord(input logic [KEY_WIDTH-1:0] v,
                                               input logic sgn);
    logic [KEY_WIDTH-1:0] r;
    r = v;
    r[KEY_WIDTH-1] = v[KEY_WIDTH-1] ^ sgn;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == qse_pkg::ST_IDLE);
  assign s_beat    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign lo_d = stk_q[IW-1:0];
  assign hi_d = stk_q[2*IW-1:IW];
  assign skip = (lo_d >= hi_d) || (CW'(hi_d) >= count);
  assign less = ord(rd_a, signed_compare) < pivot;

  always_comb begin
    key_w = '0;
    key_w[KIN-1:0] = s_tdata[KIN-1:0];
    out_key = '0;
    out_key[KIN-1:0] = rd_a[KIN-1:0];
  end

  qse_key_ram #(.DEPTH(MAX_KEYS), .WIDTH(KEY_WIDTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wa),
    .wdata   (wd),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    state_next = state;
    we     = 1'b0;
    wa     = i;
    wd     = rd_a;
    ra     = j;
    rb     = i;
    stk_we = 1'b0;
    stk_wa = sp[IW-1:0];
    stk_wd = {hi, lo};
    stk_ra = IW'(sp - CW'(1));
    load   = 1'b0;
    case (state)
      qse_pkg::ST_IDLE: begin
        if (s_beat) begin
          we = count < CW'(MAX_KEYS);
          wa = count[IW-1:0];
          wd = key_w;
          if (s_tlast) state_next = qse_pkg::ST_START;
        end
      end
      qse_pkg::ST_START: begin
        if (count < CW'(2)) begin
          state_next = qse_pkg::ST_EMIT_RD;
        end else begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = {IW'(count - CW'(1)), {IW{1'b0}}};
          state_next = qse_pkg::ST_POP;
        end
      end
      qse_pkg::ST_POP: begin
        state_next = (sp == '0) ? qse_pkg::ST_EMIT_RD : qse_pkg::ST_POP_W;
      end
      qse_pkg::ST_POP_W: begin
        ra = hi_d;
        state_next = skip ? qse_pkg::ST_POP : qse_pkg::ST_PIV;
      end
      qse_pkg::ST_PIV: state_next = qse_pkg::ST_SCAN_RD;
      qse_pkg::ST_SCAN_RD: begin
        if (j == hi) begin
          ra = i;
          rb = hi;
          state_next = qse_pkg::ST_FIN_W1;
        end else begin
          state_next = qse_pkg::ST_SCAN_CMP;
        end
      end
      qse_pkg::ST_SCAN_CMP: begin
        // key[j] goes to slot i; the old key[i] follows next cycle
        if (less && i != j) begin
          we = 1'b1;
          state_next = qse_pkg::ST_SWAP2;
        end else begin
          state_next = qse_pkg::ST_SCAN_RD;
        end
      end
      qse_pkg::ST_SWAP2: begin
        // j has already stepped on
        we = 1'b1;
        wa = j - IW'(1);
        wd = tmp;
        state_next = qse_pkg::ST_SCAN_RD;
      end
      qse_pkg::ST_FIN_W1: begin
        we = 1'b1;
        wd = rd_b;
        state_next = qse_pkg::ST_FIN_W2;
      end
      qse_pkg::ST_FIN_W2: begin
        we = 1'b1;
        wa = hi;
        wd = tmp;
        state_next = qse_pkg::ST_PUSH_HI;
      end
      qse_pkg::ST_PUSH_HI: begin
        stk_we = (CW'(i) + CW'(1)) < CW'(hi);
        stk_wd = {hi, IW'(i + IW'(1))};
        state_next = qse_pkg::ST_PUSH_LO;
      end
      qse_pkg::ST_PUSH_LO: begin
        stk_we = CW'(i) > (CW'(lo) + CW'(1));
        stk_wd = {IW'(i - IW'(1)), lo};
        state_next = qse_pkg::ST_POP;
      end
      qse_pkg::ST_EMIT_RD: begin
        ra = k;
        state_next = qse_pkg::ST_EMIT_LD;
      end
      qse_pkg::ST_EMIT_LD: begin
        ra = k;
        if (out_free) begin
          load = 1'b1;
          state_next = (CW'(k) == count - CW'(1)) ? qse_pkg::ST_IDLE
                                                   : qse_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = qse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack[stk_wa] <= stk_wd;
    stk_q <= stack[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= qse_pkg::ST_IDLE;
      signed_compare <= 1'b1;
      count          <= '0;
      dropped        <= 1'b0;
      sp             <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) signed_compare <= cfg_data;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        qse_pkg::ST_IDLE: begin
          if (s_beat) begin
            if (count < CW'(MAX_KEYS)) count <= count + CW'(1);
            else dropped <= 1'b1;
          end
        end
        qse_pkg::ST_START: if (stk_we) sp <= CW'(1);
        qse_pkg::ST_POP: if (sp != '0) sp <= sp - CW'(1);
        qse_pkg::ST_PUSH_HI, qse_pkg::ST_PUSH_LO: if (stk_we) sp <= sp + CW'(1);
        qse_pkg::ST_EMIT_LD: begin
          if (load && CW'(k) == count - CW'(1)) begin
            count   <= '0;
            dropped <= 1'b0;
            sp      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      qse_pkg::ST_START: k <= '0;
      qse_pkg::ST_POP_W: begin
        lo <= lo_d;
        hi <= hi_d;
        i  <= lo_d;
        j  <= lo_d;
      end
      qse_pkg::ST_PIV: pivot <= ord(rd_a, signed_compare);
      qse_pkg::ST_SCAN_CMP: begin
        tmp <= rd_b;
        j   <= j + IW'(1);
        if (less) i <= i + IW'(1);
      end
      qse_pkg::ST_FIN_W1: tmp <= rd_a;
      qse_pkg::ST_EMIT_LD: begin
        if (load) begin
          m_tdata <= out_key;
          m_tlast <= CW'(k) == count - CW'(1);
          m_tuser <= dropped;
          k       <= k + IW'(1);
        end
      end
      default: ;
    endcase
  end

  `QSE_ASSERT_NOW(a_sp_bound, 1'b1, sp <= CW'(MAX_KEYS), "range stack pointer out of bounds")
  `QSE_ASSERT_NOW(a_scan_order, state == qse_pkg::ST_SCAN_CMP, (i <= j) && (j < hi), "partition indices out of order")
  `QSE_ASSERT_NEXT(a_set_clear, load && CW'(k) == count - CW'(1), (count == '0) && !dropped && (state == qse_pkg::ST_IDLE), "set not cleared after final key")

endmodule
